[hw/rtl/gpd_pkg.sv]
// Shared types, constants and the sigmoid table for the 3x3 grid peak detector.
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int GRID_WIDTH_DEF  = 16;
  localparam int GRID_HEIGHT_DEF = 9;

  // Four cells can be judged per input; the fifth slot is the end-of-frame marker.
  localparam int NUM_JUDGE  = 4;
  localparam int NUM_SLOT   = 5;
  localparam int MARK_SLOT  = 4;
  localparam int WIN_SIZE   = 9;
  localparam int WIN_CENTER = 4;

  localparam logic signed [15:0] BG_ONE       = 16'sd256;
  localparam logic signed [16:0] DIFF_LIMIT   = 17'sd2048;
  localparam logic [15:0]        THRESH_RESET = 16'd32768;
  localparam logic [12:0]        DIFF_OFFSET  = 13'd2048;

  typedef struct packed {
    logic signed [15:0] background_score;
    logic signed [15:0] foreground_score;
    logic               batch_end;
  } item_t;

  typedef struct packed {
    logic        detection_valid;
    logic [3:0]  cell_column;
    logic [3:0]  cell_row;
    logic [15:0] peak_confidence;
    logic        frame_done;
    logic        batch_done;
  } result_t;

  typedef struct packed {
    logic       en;
    logic       up_ok;
    logic       down_ok;
    logic       left_ok;
    logic       right_ok;
    logic [3:0] col;
    logic [3:0] row;
  } judge_ctl_t;

  // round(65536 * sigmoid(k/2 - 8)), k = 0..32; indexes past the end hold the top point
  function automatic logic [15:0] sig_point(input logic [5:0] k);
    logic [15:0] v;
    case (k)
      6'd0:    v = 16'd22;
      6'd1:    v = 16'd36;
      6'd2:    v = 16'd60;
      6'd3:    v = 16'd98;
      6'd4:    v = 16'd162;
      6'd5:    v = 16'd267;
      6'd6:    v = 16'd439;
      6'd7:    v = 16'd720;
      6'd8:    v = 16'd1179;
      6'd9:    v = 16'd1921;
      6'd10:   v = 16'd3108;
      6'd11:   v = 16'd4971;
      6'd12:   v = 16'd7812;
      6'd13:   v = 16'd11955;
      6'd14:   v = 16'd17625;
      6'd15:   v = 16'd24743;
      6'd16:   v = 16'd32768;
      6'd17:   v = 16'd40793;
      6'd18:   v = 16'd47911;
      6'd19:   v = 16'd53581;
      6'd20:   v = 16'd57724;
      6'd21:   v = 16'd60565;
      6'd22:   v = 16'd62428;
      6'd23:   v = 16'd63615;
      6'd24:   v = 16'd64357;
      6'd25:   v = 16'd64816;
      6'd26:   v = 16'd65097;
      6'd27:   v = 16'd65269;
      6'd28:   v = 16'd65374;
      6'd29:   v = 16'd65438;
      6'd30:   v = 16'd65476;
      6'd31:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/gpd_cell.sv]
// One stage of the score line: holds one cell's scores and hands them on each transfer.
`timescale 1ns / 1ps

module gpd_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic signed [15:0] d_fg,
  input  logic signed [15:0] d_bg,
  output logic signed [15:0] q_fg,
  output logic signed [15:0] q_bg
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q_fg <= d_fg;
      q_bg <= d_bg;
    end
  end

endmodule

[hw/rtl/gpd_judge.sv]
// Two-stage judge of one cell: neighbor test and sigmoid lookup, then interpolation and threshold.
`timescale 1ns / 1ps

module gpd_judge (
  input  logic                 clk,
  input  logic                 load1,
  input  logic                 load2,
  input  gpd_pkg::judge_ctl_t  ctl,
  input  logic signed [15:0]   win [gpd_pkg::WIN_SIZE],
  input  logic signed [15:0]   bg,
  input  logic [15:0]          thr,
  output gpd_pkg::result_t     res,
  output logic                 hit_next
);
  import gpd_pkg::*;

  logic signed [16:0] diff;
  logic signed [12:0] dcl;
  logic [12:0]        off;
  logic [5:0]         idx;
  logic [15:0]        t0_c;
  logic [15:0]        t1_c;
  logic [WIN_SIZE-1:0] larger;

  logic [15:0] t0;
  logic [15:0] delta;
  logic [6:0]  frac;
  logic        ok;
  logic [3:0]  col;
  logic [3:0]  row;

  logic [22:0] prod;
  logic [23:0] rnd;
  logic [16:0] conf_sum;
  logic [15:0] conf;

  // Neighbor masks follow the window layout: rows above, center, below; columns left to right.
  for (genvar j = 0; j < WIN_SIZE; j++) begin : g_nb
    localparam int DY = j / 3;
    localparam int DX = j % 3;
    logic row_ok;
    logic col_ok;
    assign row_ok = (DY == 0) ? ctl.up_ok : ((DY == 2) ? ctl.down_ok : 1'b1);
    assign col_ok = (DX == 0) ? ctl.left_ok : ((DX == 2) ? ctl.right_ok : 1'b1);
    assign larger[j] = row_ok && col_ok && (win[j] > win[WIN_CENTER]);
  end

  always_comb begin
    diff = 17'(win[WIN_CENTER]) - 17'(bg);
    if (diff > DIFF_LIMIT) begin
      dcl = 13'sd2048;
    end else if (diff < -DIFF_LIMIT) begin
      dcl = -13'sd2048;
    end else begin
      dcl = diff[12:0];
    end
    off  = $unsigned(dcl) + DIFF_OFFSET;
    idx  = off[12:7];
    t0_c = sig_point(idx);
    t1_c = sig_point(idx + 6'd1);
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      t0    <= t0_c;
      delta <= t1_c - t0_c;
      frac  <= off[6:0];
      ok    <= ctl.en && (larger == '0) && (bg != BG_ONE);
      col   <= ctl.col;
      row   <= ctl.row;
    end
  end

  always_comb begin
    prod     = 23'(delta) * 23'(frac);
    rnd      = 24'(prod) + 24'd64;
    conf_sum = 17'(t0) + 17'(rnd[23:7]);
    conf     = conf_sum[15:0];
    hit_next = ok && (conf >= thr);
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      res.detection_valid <= 1'b1;
      res.cell_column     <= col;
      res.cell_row        <= row;
      res.peak_confidence <= conf;
      res.frame_done      <= 1'b0;
      res.batch_done      <= 1'b0;
    end
  end

endmodule

[hw/rtl/grid_peak_detector_3x3_core.sv]
// Streaming 3x3 peak detector on a score grid: score line, four judges, result set and output.
// Path: stage s0, judge first stage, judge results with the result set, then the output register.
// Throughput: one item per cycle while each item causes at most one result and the output is
//   not stalled; an item causing more results (up to five at a frame's last cell) holds back
//   later items while the single output register drains the set one entry per unstalled cycle.
// Reset clears counters, stage valid bits and the output; threshold returns to 0.5 (32768).
`timescale 1ns / 1ps

module grid_peak_detector_3x3_core #(
  parameter int GRID_WIDTH  = gpd_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gpd_pkg::GRID_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gpd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output gpd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import gpd_pkg::*;

  localparam int CW        = $clog2(GRID_WIDTH);
  localparam int RW        = $clog2(GRID_HEIGHT);
  localparam int CHAIN_LEN = 2 * GRID_WIDTH + 3;
  localparam int SW        = $clog2(NUM_SLOT);

  logic [15:0] thr;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic          accept;
  logic          last_col;
  logic          last_row;

  logic          s0_v;
  logic [CW-1:0] s0_col;
  logic [RW-1:0] s0_row;
  logic          s0_bend;
  logic          s0_last_col;
  logic          s0_last_row;

  logic s1_v;
  logic s1_mark;
  logic s1_bend;
  logic mark_bdone;

  logic load1;
  logic load2;

  logic [NUM_SLOT-1:0] pend;
  logic [NUM_SLOT-1:0] pend_low;
  logic [NUM_SLOT-1:0] pend_left;
  logic [NUM_SLOT-1:0] hit_next;
  logic                set_free;
  logic                out_free;
  logic                take;
  logic [SW-1:0]       sel_idx;
  result_t             sel_res;
  result_t             mark_res;

  logic signed [15:0] fg_tap [CHAIN_LEN];
  logic signed [15:0] bg_tap [CHAIN_LEN];

  judge_ctl_t         ctl  [NUM_JUDGE];
  logic signed [15:0] win  [NUM_JUDGE][WIN_SIZE];
  logic signed [15:0] bgc  [NUM_JUDGE];
  result_t            jres [NUM_JUDGE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // Score line: cell 0 holds the newest cell, cell i the one i transfers older.
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_line
    if (i == 0) begin : g_head
      gpd_cell u_cell (
        .clk  (clk),
        .shift(accept),
        .d_fg (item.foreground_score),
        .d_bg (item.background_score),
        .q_fg (fg_tap[i]),
        .q_bg (bg_tap[i])
      );
    end else begin : g_body
      gpd_cell u_cell (
        .clk  (clk),
        .shift(accept),
        .d_fg (fg_tap[i-1]),
        .d_bg (bg_tap[i-1]),
        .q_fg (fg_tap[i]),
        .q_bg (bg_tap[i])
      );
    end
  end

  // Position of the newest cell
  assign accept   = item_valid && item_ready;
  assign last_col = (col_cnt == CW'(GRID_WIDTH - 1));
  assign last_row = (row_cnt == RW'(GRID_HEIGHT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_col      <= col_cnt;
      s0_row      <= row_cnt;
      s0_bend     <= item.batch_end;
      s0_last_col <= last_col;
      s0_last_row <= last_row;
    end
  end

  // Judges: up-left of newest, up (last column), left (last row), newest (last corner).
  for (genvar k = 0; k < NUM_JUDGE; k++) begin : g_judge
    localparam int XB  = (k % 2 == 0) ? 1 : 0;
    localparam int YB  = (k < 2) ? 1 : 0;
    localparam int AGE = YB * GRID_WIDTH + XB;
    logic [CW-1:0] cx;
    logic [RW-1:0] cy;

    assign cx = s0_col - CW'(XB);
    assign cy = s0_row - RW'(YB);

    assign ctl[k].en       = ((YB == 1) ? (s0_row != '0) : s0_last_row) &&
                             ((XB == 1) ? (s0_col != '0) : s0_last_col);
    assign ctl[k].up_ok    = (cy != '0);
    assign ctl[k].down_ok  = (cy != RW'(GRID_HEIGHT - 1));
    assign ctl[k].left_ok  = (cx != '0);
    assign ctl[k].right_ok = (cx != CW'(GRID_WIDTH - 1));
    assign ctl[k].col      = 4'(cx);
    assign ctl[k].row      = 4'(cy);
    assign bgc[k]          = bg_tap[AGE];

    for (genvar j = 0; j < WIN_SIZE; j++) begin : g_tap
      localparam int DY  = j / 3 - 1;
      localparam int DX  = j % 3 - 1;
      localparam int IDX = AGE - DY * GRID_WIDTH - DX;
      // Taps that fall before the newest cell are always masked off.
      localparam int IDXC = (IDX < 0) ? 0 : IDX;
      assign win[k][j] = fg_tap[IDXC];
    end

    gpd_judge u_judge (
      .clk     (clk),
      .load1   (load1),
      .load2   (load2),
      .ctl     (ctl[k]),
      .win     (win[k]),
      .bg      (bgc[k]),
      .thr     (thr),
      .res     (jres[k]),
      .hit_next(hit_next[k])
    );
  end

  assign hit_next[MARK_SLOT] = s1_mark;

  // Result set drains lowest slot first: earlier row, then column, marker last.
  always_comb begin
    out_free  = !result_valid || result_ready;
    take      = out_free && (pend != '0);
    pend_low  = pend & (~pend + 1'b1);
    pend_left = take ? (pend & ~pend_low) : pend;
    set_free  = (pend_left == '0);
    load2     = s1_v && set_free;
    load1     = s0_v && (!s1_v || load2);
    item_ready = !s0_v || load1;

    sel_idx = '0;
    for (int i = NUM_SLOT - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel_idx = SW'(i);
      end
    end

    mark_res.detection_valid = 1'b0;
    mark_res.cell_column     = '0;
    mark_res.cell_row        = '0;
    mark_res.peak_confidence = '0;
    mark_res.frame_done      = 1'b1;
    mark_res.batch_done      = mark_bdone;

    sel_res = (sel_idx == SW'(MARK_SLOT)) ? mark_res : jres[sel_idx[1:0]];
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_mark <= s0_last_col && s0_last_row;
      s1_bend <= s0_bend;
    end
    if (load2) begin
      mark_bdone <= s1_bend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v         <= 1'b0;
      s1_v         <= 1'b0;
      pend         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s0_v <= 1'b1;
      end else if (load1) begin
        s0_v <= 1'b0;
      end

      if (load1) begin
        s1_v <= 1'b1;
      end else if (load2) begin
        s1_v <= 1'b0;
      end

      pend <= load2 ? hit_next : pend_left;

      if (take) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= sel_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (col_cnt <= CW'(GRID_WIDTH - 1)) && (row_cnt <= RW'(GRID_HEIGHT - 1)))
    else $error("position counter out of grid");

  assert property (@(posedge clk) disable iff (rst)
    s0_v && s1_v && !set_free |-> !item_ready)
    else $error("input taken while the judge stages are blocked");

  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> s0_v)
    else $error("transferred item lost before judging");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_done |-> !result.detection_valid &&
    (result.peak_confidence == '0))
    else $error("end-of-frame marker carries a detection");

endmodule

[tb/tb_grid_peak_detector_3x3_core.sv]
// Self-checking bench for the 3x3 grid peak detector: scored cells in, peaks and frame ends out.
`timescale 1ns / 1ps

module tb_grid_peak_detector_3x3_core;
  import gpd_pkg::*;

  localparam int GW          = GRID_WIDTH_DEF;
  localparam int GH          = GRID_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 20;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_LEN    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  grid_peak_detector_3x3_core #(
    .GRID_WIDTH (GW),
    .GRID_HEIGHT(GH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  int sig_pts [0:32] = '{
    22, 36, 60, 98, 162, 267, 439, 720,
    1179, 1921, 3108, 4971, 7812, 11955, 17625, 24743,
    32768,
    40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
    64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
  };

  logic signed [15:0] fg_ring [0:2][0:GW-1];
  logic signed [15:0] bg_ring [0:1][0:GW-1];
  int                 grid_col;
  int                 grid_row;
  logic [15:0]        thr_model = THRESH_RESET;
  result_t            predicted_reports [$];

  function automatic int softmax_confidence(int fg, int bg);
    int d;
    int o;
    int i;
    int f;
    d = fg - bg;
    if (d > 2048) d = 2048;
    if (d < -2048) d = -2048;
    o = d + 2048;
    i = o >> 7;
    f = o & 127;
    if (i >= 32) return sig_pts[32];
    return sig_pts[i] + (((sig_pts[i+1] - sig_pts[i]) * f + 64) >> 7);
  endfunction

  function automatic void judge_cell(int x, int y);
    int      fg;
    int      bg;
    int      conf;
    int      nb;
    result_t r;
    fg   = fg_ring[y % 3][x];
    bg   = bg_ring[y % 2][x];
    conf = softmax_confidence(fg, bg);
    if (conf < int'(thr_model) || bg == int'(BG_ONE)) return;
    for (int oy = y - 1; oy <= y + 1; oy++) begin
      if (oy < 0 || oy >= GH) continue;
      for (int ox = x - 1; ox <= x + 1; ox++) begin
        if (ox < 0 || ox >= GW) continue;
        nb = fg_ring[oy % 3][ox];
        if (fg < nb) return;
      end
    end
    r                 = '0;
    r.detection_valid = 1'b1;
    r.cell_column     = x[3:0];
    r.cell_row        = y[3:0];
    r.peak_confidence = conf[15:0];
    predicted_reports = {predicted_reports, r};
  endfunction

  function automatic void predict_cell(item_t it);
    int      c;
    int      r;
    bit      last_col;
    bit      last_row;
    result_t mark;
    c        = grid_col;
    r        = grid_row;
    last_col = (c == GW - 1);
    last_row = (r == GH - 1);
    bg_ring[r % 2][c] = it.background_score;
    fg_ring[r % 3][c] = it.foreground_score;
    if (r >= 1) begin
      if (c >= 1) judge_cell(c - 1, r - 1);
      if (last_col) judge_cell(c, r - 1);
    end
    if (last_row) begin
      if (c >= 1) judge_cell(c - 1, r);
      if (last_col) judge_cell(c, r);
    end
    if (last_col && last_row) begin
      mark            = '0;
      mark.frame_done = 1'b1;
      mark.batch_done = it.batch_end;
      predicted_reports = {predicted_reports, mark};
      grid_col = 0;
      grid_row = 0;
    end else if (last_col) begin
      grid_col = 0;
      grid_row = r + 1;
    end else begin
      grid_col = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------- driver
  item_t cell_queue [$];
  int    cells_queued   = 0;
  int    items_accepted = 0;
  int    burst_left     = 0;
  int    gap_left       = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      grid_col = 0;
      grid_row = 0;
    end else begin
      if (item_valid && item_ready) begin
        predict_cell(item);
        items_accepted <= items_accepted + 1;
      end
      if (!item_valid || item_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          item       <= cell_queue[0];
          cell_queue.delete(0);
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_cnt  = 0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  bit ready_phase = 1'b1;

  // Hold off the output once for a long stretch so the input backs up.
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            ready_phase = 1'b1;
            stall_left  = $urandom_range(40, 80);
          end
          1, 2: begin
            ready_phase = 1'b0;
            stall_left  = $urandom_range(1, 8);
          end
          default: begin
            ready_phase = 1'b1;
            stall_left  = $urandom_range(1, 6);
          end
        endcase
      end
      result_ready <= ready_phase && (hold_cnt == 0);
    end
  end

  // ---------------------------------------------------------------- monitor
  int      mismatches = 0;
  result_t want_res;

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (predicted_reports.size() == 0) begin
        report_mismatch("result transfer with nothing predicted");
      end else begin
        want_res = predicted_reports[0];
        predicted_reports.delete(0);
        check_field("detection_valid", result.detection_valid, want_res.detection_valid);
        check_field("cell_column", result.cell_column, want_res.cell_column);
        check_field("cell_row", result.cell_row, want_res.cell_row);
        check_field("peak_confidence", result.peak_confidence, want_res.peak_confidence);
        check_field("frame_done", result.frame_done, want_res.frame_done);
        check_field("batch_done", result.batch_done, want_res.batch_done);
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic item_t make_cell(int bg, int fg, bit be);
    item_t c;
    c.background_score = 16'(bg);
    c.foreground_score = 16'(fg);
    c.batch_end        = be;
    return c;
  endfunction

  function automatic item_t random_cell();
    item_t c;
    int    kind;
    int    a;
    int    b;
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 15) begin
      // keep the difference within +/-3072, mostly inside the +/-2048 clamp, so the table interpolation is exercised
      a = int'($urandom_range(0, 3072)) - 1536;
      b = int'($urandom_range(0, 3072)) - 1536;
    end else begin
      // few distinct values: plenty of equal neighbours
      a = (int'($urandom_range(0, 2)) - 1) * 256;
      b = (int'($urandom_range(0, 4)) - 2) * 256;
    end
    c = make_cell(a, b, $urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) c.background_score = BG_ONE;
    return c;
  endfunction

  task automatic push_cell(item_t c);
    // alternate batch_end on the last cell of each frame
    if (cells_queued % (GW * GH) == GW * GH - 1)
      c.batch_end = ((cells_queued / (GW * GH)) % 2) == 0;
    cell_queue = {cell_queue, c};
    cells_queued++;
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) push_cell(random_cell());
  endtask

  task automatic wait_idle();
    while (items_accepted != cells_queued || predicted_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  logic [15:0] thr_plan [0:9];

  initial begin
    thr_plan = '{16'd0, 16'd65535, 16'd65514, 16'd65515, 16'd1, 16'd32767,
                 16'd0, 16'd0, 16'd0, 16'd32768};
    for (int k = 6; k < 9; k++) thr_plan[k] = $urandom_range(0, 65535);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Row 0: field extremes, clamp edges, background exactly one, ties
    push_cell(make_cell(-32768, 32767, 1'b0));
    push_cell(make_cell(32767, -32768, 1'b1));
    push_cell(make_cell(256, 32767, 1'b0));
    push_cell(make_cell(0, 0, 1'b1));
    push_cell(make_cell(0, -1, 1'b0));
    push_cell(make_cell(255, 2302, 1'b0));
    push_cell(make_cell(257, 2305, 1'b1));
    push_cell(make_cell(-2049, 0, 1'b0));
    push_cell(make_cell(2048, 0, 1'b0));
    push_cell(make_cell(2049, 0, 1'b1));
    push_cell(make_cell(0, 127, 1'b0));
    push_cell(make_cell(0, 128, 1'b0));
    push_cell(make_cell(-32768, -32768, 1'b1));
    push_cell(make_cell(32767, 32767, 1'b0));
    push_cell(make_cell(256, 0, 1'b0));
    push_cell(make_cell(100, 100, 1'b1));
    // Row 1: neighbours equal to and just above row 0 scores
    push_cell(make_cell(-300, 32767, 1'b0));
    push_cell(make_cell(0, 32766, 1'b1));
    push_cell(make_cell(0, 32767, 1'b0));
    push_cell(make_cell(-1, 0, 1'b0));
    push_cell(make_cell(1, 0, 1'b1));
    push_cell(make_cell(0, -32768, 1'b0));
    queue_random(60);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_threshold(thr_plan[p]);
      queue_random(36);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
